[rtl/core/ldsi_pkg.sv]
package ldsi_pkg;

	// Channel widths
	localparam int unsigned S_DATA_W  = 32;
	localparam int unsigned S_USER_W  = 1;
	localparam int unsigned M_DATA_W  = 224;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned LOG_W     = 8;
	localparam int unsigned NS_W      = 64;

	// Input word kinds carried on s_tuser
	localparam logic OP_LATCH = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INIT_PDELAY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_SYNC     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_ANNOUNCE = 2'd2;

	// Reset values of the initial log intervals
	localparam logic signed [LOG_W-1:0] RST_INIT_PDELAY   = 8'sd0;
	localparam logic signed [LOG_W-1:0] RST_INIT_SYNC     = -8'sd3;
	localparam logic signed [LOG_W-1:0] RST_INIT_ANNOUNCE = 8'sd0;

	// Special message log values
	localparam logic signed [LOG_W-1:0] LOG_KEEP    = -8'sd128;
	localparam logic signed [LOG_W-1:0] LOG_INITIAL = 8'sd126;

	// Largest log whose interval still fits in 64 bits
	localparam logic signed [LOG_W-1:0] LOG_MAX_FIT = 8'sd34;

	localparam logic [NS_W-1:0] NS_PER_SECOND = 64'd1_000_000_000;

	// Reported machine state codes
	localparam logic [1:0] FSM_NOT_ENABLED   = 2'd0;
	localparam logic [1:0] FSM_INITIALIZING  = 2'd1;
	localparam logic [1:0] FSM_SET_INTERVALS = 2'd2;

	typedef enum logic [2:0] {
		ST_NOT_ENABLED   = 3'b001,
		ST_INITIALIZING  = 3'b010,
		ST_SET_INTERVALS = 3'b100
	} state_t;

	// Convert a log2-seconds interval to nanoseconds, truncated and saturated
	function automatic logic [NS_W-1:0] log_to_ns(input logic signed [LOG_W-1:0] lg);
		logic [LOG_W-1:0] neg_l;
		neg_l = 8'd0 - lg;
		if (lg > LOG_MAX_FIT)
			return '1;
		else if (lg >= 8'sd0)
			return NS_PER_SECOND << lg[5:0];
		else if (neg_l >= 8'd64 || lg == LOG_KEEP)
			return '0;
		else
			return NS_PER_SECOND >> neg_l[5:0];
	endfunction

endpackage

[rtl/core/link_delay_sync_interval_setting.sv]
// Channel   | Dir | Handshake           | Payload
// ----------+-----+---------------------+-------------------------------------------
// s_        | in  | s_tvalid / s_tready | s_tuser: op; s_tdata: enables, message
// m_        | out | m_tvalid / m_tready | m_tdata: state, logs, intervals, flags
// cfg_      | in  | cfg_valid/cfg_ready | cfg_index, cfg_data: initial log intervals
//
// One word in, one word out; a new word is taken every cycle unless a result is stalled.
// The machine state registers double as the result register, so a result
// appears the cycle after its word is accepted.
// A stalled result (m_tvalid high, m_tready low) holds s_tready low.
// arst_n clears the machine state and loads the default initial log intervals.
// Configuration writes are taken in any cycle.
module link_delay_sync_interval_setting (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [0] begin_req, [1] port_enabled, [2] ptt_enabled, [10:3] msg_link_delay_log,
	// [18:11] msg_sync_log, [26:19] msg_announce_log, [27] msg_rate_ratio_flag,
	// [28] msg_prop_delay_flag, [31:29] zero
	input  logic [ldsi_pkg::S_DATA_W-1:0]      s_tdata,
	// [0] op
	input  logic [ldsi_pkg::S_USER_W-1:0]      s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [1:0] fsm_state, [9:2] cur_log_pdelay, [17:10] cur_log_sync,
	// [25:18] cur_log_announce, [89:26] pdelay_ns, [153:90] sync_ns,
	// [217:154] announce_ns, [218] rate_ratio_on, [219] prop_delay_on, [223:220] zero
	output logic [ldsi_pkg::M_DATA_W-1:0]      m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ldsi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ldsi_pkg::LOG_W-1:0]         cfg_data
);
	import ldsi_pkg::*;

	// Configuration
	logic signed [LOG_W-1:0] init_pdelay_q, init_sync_q, init_announce_q;

	// Machine state, also the result word
	state_t                  state_q;
	logic                    pending_q;
	logic signed [LOG_W-1:0] held_link_q, held_sync_q, held_announce_q;
	logic [1:0]              held_flags_q;
	logic signed [LOG_W-1:0] cur_pdelay_q, cur_sync_q, cur_announce_q;
	logic [NS_W-1:0]         pdelay_ns_q, sync_ns_q, announce_ns_q;
	logic [1:0]              compute_q;
	logic                    m_tvalid_q;

	// Unpacked input word
	logic                    op;
	logic                    begin_req, port_enabled, ptt_enabled;
	logic signed [LOG_W-1:0] msg_link_log, msg_sync_log, msg_announce_log;
	logic [1:0]              msg_flags;

	logic                    accept;
	logic                    disable_req, do_load, do_apply;
	logic [1:0]              fsm_code;
	logic signed [LOG_W-1:0] nxt_pdelay_log, nxt_sync_log, nxt_announce_log;
	logic [NS_W-1:0]         nxt_pdelay_ns, nxt_sync_ns, nxt_announce_ns;

	assign op               = s_tuser[0];
	assign begin_req        = s_tdata[0];
	assign port_enabled     = s_tdata[1];
	assign ptt_enabled      = s_tdata[2];
	assign msg_link_log     = s_tdata[10:3];
	assign msg_sync_log     = s_tdata[18:11];
	assign msg_announce_log = s_tdata[26:19];
	assign msg_flags        = s_tdata[28:27];

	// Take a new word unless a result is stalled
	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Decide what an evaluation word does
	assign disable_req = begin_req || !port_enabled || !ptt_enabled;
	assign do_load     = accept && op == OP_EVAL && !disable_req && state_q == ST_NOT_ENABLED;
	assign do_apply    = accept && op == OP_EVAL && !disable_req && pending_q &&
	                     (state_q == ST_INITIALIZING || state_q == ST_SET_INTERVALS);

	ldsi_interval u_pdelay (
		.load_init (do_load),
		.msg_log   (held_link_q),
		.init_log  (init_pdelay_q),
		.cur_log   (cur_pdelay_q),
		.cur_ns    (pdelay_ns_q),
		.nxt_log   (nxt_pdelay_log),
		.nxt_ns    (nxt_pdelay_ns)
	);

	ldsi_interval u_sync (
		.load_init (do_load),
		.msg_log   (held_sync_q),
		.init_log  (init_sync_q),
		.cur_log   (cur_sync_q),
		.cur_ns    (sync_ns_q),
		.nxt_log   (nxt_sync_log),
		.nxt_ns    (nxt_sync_ns)
	);

	ldsi_interval u_announce (
		.load_init (1'b0),
		.msg_log   (held_announce_q),
		.init_log  (init_announce_q),
		.cur_log   (cur_announce_q),
		.cur_ns    (announce_ns_q),
		.nxt_log   (nxt_announce_log),
		.nxt_ns    (nxt_announce_ns)
	);

	// Write configuration registers, drop indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_pdelay_q   <= RST_INIT_PDELAY;
			init_sync_q     <= RST_INIT_SYNC;
			init_announce_q <= RST_INIT_ANNOUNCE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INIT_PDELAY:   init_pdelay_q   <= cfg_data;
				REG_INIT_SYNC:     init_sync_q     <= cfg_data;
				REG_INIT_ANNOUNCE: init_announce_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latch messages and advance the machine on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_NOT_ENABLED;
			pending_q       <= 1'b0;
			held_link_q     <= '0;
			held_sync_q     <= '0;
			held_announce_q <= '0;
			held_flags_q    <= '0;
			cur_pdelay_q    <= '0;
			cur_sync_q      <= '0;
			cur_announce_q  <= '0;
			pdelay_ns_q     <= '0;
			sync_ns_q       <= '0;
			announce_ns_q   <= '0;
			compute_q       <= '0;
		end else begin
			if (accept && op == OP_LATCH) begin
				held_link_q     <= msg_link_log;
				held_sync_q     <= msg_sync_log;
				held_announce_q <= msg_announce_log;
				held_flags_q    <= msg_flags;
				pending_q       <= 1'b1;
			end
			if (accept && op == OP_EVAL && disable_req) begin
				state_q <= ST_NOT_ENABLED;
			end
			if (do_load || do_apply) begin
				cur_pdelay_q <= nxt_pdelay_log;
				cur_sync_q   <= nxt_sync_log;
				pdelay_ns_q  <= nxt_pdelay_ns;
				sync_ns_q    <= nxt_sync_ns;
				pending_q    <= 1'b0;
			end
			if (do_load) begin
				compute_q <= 2'b11;
				state_q   <= ST_INITIALIZING;
			end
			if (do_apply) begin
				cur_announce_q <= nxt_announce_log;
				announce_ns_q  <= nxt_announce_ns;
				compute_q      <= held_flags_q;
				state_q        <= ST_SET_INTERVALS;
			end
		end
	end

	// Raise a result after each accepted word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= accept || (m_tvalid_q && !m_tready);
		end
	end

	// Encode the one-hot state for the result word
	always_comb begin
		unique case (state_q)
			ST_NOT_ENABLED:   fsm_code = FSM_NOT_ENABLED;
			ST_INITIALIZING:  fsm_code = FSM_INITIALIZING;
			ST_SET_INTERVALS: fsm_code = FSM_SET_INTERVALS;
			default:          fsm_code = FSM_NOT_ENABLED;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, compute_q[1], compute_q[0],
	                   announce_ns_q, sync_ns_q, pdelay_ns_q,
	                   cur_announce_q, cur_sync_q, cur_pdelay_q, fsm_code};

endmodule

[rtl/core/ldsi_interval.sv]
module ldsi_interval (
	input  logic                               load_init,
	input  logic signed [ldsi_pkg::LOG_W-1:0]  msg_log,
	input  logic signed [ldsi_pkg::LOG_W-1:0]  init_log,
	input  logic signed [ldsi_pkg::LOG_W-1:0]  cur_log,
	input  logic        [ldsi_pkg::NS_W-1:0]   cur_ns,
	output logic signed [ldsi_pkg::LOG_W-1:0]  nxt_log,
	output logic        [ldsi_pkg::NS_W-1:0]   nxt_ns
);
	import ldsi_pkg::*;

	logic signed [LOG_W-1:0] sel_log;
	logic                    keep;

	// Pick the log to apply: initial on load or on request, else the message value
	always_comb begin
		keep    = 1'b0;
		sel_log = msg_log;
		if (load_init || msg_log == LOG_INITIAL) begin
			sel_log = init_log;
		end else if (msg_log == LOG_KEEP) begin
			keep = 1'b1;
		end
	end

	// Hold the current interval when the message says keep
	always_comb begin
		if (keep) begin
			nxt_log = cur_log;
			nxt_ns  = cur_ns;
		end else begin
			nxt_log = sel_log;
			nxt_ns  = log_to_ns(sel_log);
		end
	end

endmodule

[rtl/core/ldsi_checker.sv]
module ldsi_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [ldsi_pkg::S_DATA_W-1:0]      s_tdata,
	input logic [ldsi_pkg::S_USER_W-1:0]      s_tuser,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [ldsi_pkg::M_DATA_W-1:0]      m_tdata
);
	import ldsi_pkg::*;

	// Input side stalls only behind an untaken result
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow the output register");

	// Every accepted word gives a result in the next cycle
	a_result_follows_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted word produced no result");

	// A begin or disable evaluation always reports not enabled
	a_disable_reports_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == OP_EVAL &&
		 (s_tdata[0] || !s_tdata[1] || !s_tdata[2]))
		|=> m_tdata[1:0] == FSM_NOT_ENABLED)
		else $error("disable evaluation did not return to not enabled");

	// The unused state code never shows
	a_state_code_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("unused state code on the result word");

	// Hold a stalled result word
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result word changed");

endmodule

bind link_delay_sync_interval_setting ldsi_checker u_ldsi_checker (.*);

[verif/link_delay_sync_interval_setting_test.sv]
module link_delay_sync_interval_setting_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ldsi_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 250_000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// Input word, packed as on s_tdata (first member is the top bit)
	typedef struct packed {
		logic [2:0] pad;
		logic       prop_flag;
		logic       rate_flag;
		logic [7:0] announce_log;
		logic [7:0] sync_log;
		logic [7:0] link_log;
		logic       ptt_enabled;
		logic       port_enabled;
		logic       begin_req;
	} port_word_t;

	// Result word, packed as on m_tdata below the zero fill
	typedef struct packed {
		logic        prop_on;
		logic        rate_on;
		logic [63:0] announce_ns;
		logic [63:0] sync_ns;
		logic [63:0] pdelay_ns;
		logic [7:0]  announce_log;
		logic [7:0]  sync_log;
		logic [7:0]  pdelay_log;
		logic [1:0]  state;
	} interval_view_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata   = '0;
	logic [S_USER_W-1:0]  s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LOG_W-1:0]     cfg_data  = '0;

	// Port machine as predicted by the testbench
	logic [1:0]  port_state;
	logic        msg_pending;
	port_word_t  held_msg;
	logic [7:0]  cur_log [3];
	logic [63:0] cur_ns [3];
	logic [1:0]  compute_on;
	logic [7:0]  init_log [3];

	interval_view_t expected_views [$];
	int unsigned    mismatches = 0;
	bit             src_idle = 1'b1;
	bit             sink_idle = 1'b1;

	link_delay_sync_interval_setting dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// 1e9 * 2^lg ns, truncated; all ones once it no longer fits
	function automatic logic [63:0] nanos_for_log(logic signed [7:0] lg);
		int n;
		n = lg;
		if (n > 34)
			return '1;
		if (n >= 0)
			return NS_PER_SECOND << n;
		if (n <= -64)
			return '0;
		return NS_PER_SECOND >> (-n);
	endfunction

	// Keep, restore the initial value, or take the message value as given
	task automatic refresh_interval(int idx, logic [7:0] msg_log);
		if (msg_log == LOG_KEEP)
			return;
		if (msg_log == LOG_INITIAL)
			cur_log[idx] = init_log[idx];
		else
			cur_log[idx] = msg_log;
		cur_ns[idx] = nanos_for_log(cur_log[idx]);
	endtask

	// Advance the predicted machine by one accepted word and queue its result
	task automatic predict_word(logic op, port_word_t w);
		interval_view_t v;
		if (op == OP_LATCH) begin
			held_msg    = w;
			msg_pending = 1'b1;
		end else if (w.begin_req || !w.port_enabled || !w.ptt_enabled) begin
			port_state = FSM_NOT_ENABLED;
		end else if (port_state == FSM_NOT_ENABLED) begin
			// announce interval is left as it was
			cur_log[0]  = init_log[0];
			cur_log[1]  = init_log[1];
			cur_ns[0]   = nanos_for_log(init_log[0]);
			cur_ns[1]   = nanos_for_log(init_log[1]);
			compute_on  = 2'b11;
			msg_pending = 1'b0;
			port_state  = FSM_INITIALIZING;
		end else if (msg_pending) begin
			refresh_interval(0, held_msg.link_log);
			refresh_interval(1, held_msg.sync_log);
			refresh_interval(2, held_msg.announce_log);
			compute_on  = {held_msg.prop_flag, held_msg.rate_flag};
			msg_pending = 1'b0;
			port_state  = FSM_SET_INTERVALS;
		end
		v.state        = port_state;
		v.pdelay_log   = cur_log[0];
		v.sync_log     = cur_log[1];
		v.announce_log = cur_log[2];
		v.pdelay_ns    = cur_ns[0];
		v.sync_ns      = cur_ns[1];
		v.announce_ns  = cur_ns[2];
		v.rate_on      = compute_on[0];
		v.prop_on      = compute_on[1];
		expected_views.push_back(v);
	endtask

	// Send one word, with an optional gap before it; valid stays high afterwards
	task automatic send_word(logic op, port_word_t w);
		int unsigned gap;
		gap = (src_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		predict_word(op, w);
	endtask

	function automatic port_word_t latch_word(logic [7:0] link, logic [7:0] sync,
			logic [7:0] announce, logic rate, logic prop);
		port_word_t w;
		w              = '0;
		w.link_log     = link;
		w.sync_log     = sync;
		w.announce_log = announce;
		w.rate_flag    = rate;
		w.prop_flag    = prop;
		return w;
	endfunction

	function automatic port_word_t eval_word(logic begin_req, logic port_en, logic ptt_en);
		port_word_t w;
		w              = '0;
		w.begin_req    = begin_req;
		w.port_enabled = port_en;
		w.ptt_enabled  = ptt_en;
		return w;
	endfunction

	// Drop valid and wait until every expected word is back
	task automatic settle_port();
		s_tvalid <= 1'b0;
		while (expected_views.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write all three initial logs plus the unused index, which must be ignored
	task automatic set_init_logs(logic [7:0] pdelay, logic [7:0] sync, logic [7:0] announce);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [7:0]           val [4];
		idx = '{REG_INIT_PDELAY, REG_INIT_SYNC, REG_INIT_ANNOUNCE, REG_UNUSED};
		val = '{pdelay, sync, announce, 8'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				REG_INIT_PDELAY:   init_log[0] = val[i];
				REG_INIT_SYNC:     init_log[1] = val[i];
				REG_INIT_ANNOUNCE: init_log[2] = val[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Special codes, values near the fit limits, and anything at all
	function automatic logic [7:0] pick_log();
		case ($urandom_range(0, 7))
			0:       return LOG_KEEP;
			1:       return LOG_INITIAL;
			2, 3, 4: return 8'($urandom_range(0, 75) - 36);
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly enabled evaluations and messages; unused fields carry noise
	task automatic send_random_word();
		port_word_t w;
		logic       op;
		w     = port_word_t'($urandom);
		w.pad = '0;
		if ($urandom_range(0, 9) < 4) begin
			op             = OP_LATCH;
			w.link_log     = pick_log();
			w.sync_log     = pick_log();
			w.announce_log = pick_log();
		end else begin
			op = OP_EVAL;
			if ($urandom_range(0, 9) < 8) begin
				w.begin_req    = 1'b0;
				w.port_enabled = 1'b1;
				w.ptt_enabled  = 1'b1;
			end
		end
		send_word(op, w);
	endtask

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Check each result word against the oldest prediction; drive m_tready
	initial begin : result_check
		interval_view_t got;
		interval_view_t want;
		int unsigned    stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = interval_view_t'(m_tdata[$bits(interval_view_t)-1:0]);
				if (expected_views.size() == 0) begin
					$display("%0t: result expected none actual %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = expected_views.pop_front();
					compare_field("fsm_state", want.state, got.state);
					compare_field("cur_log_pdelay", want.pdelay_log, got.pdelay_log);
					compare_field("cur_log_sync", want.sync_log, got.sync_log);
					compare_field("cur_log_announce", want.announce_log, got.announce_log);
					compare_field("pdelay_ns", want.pdelay_ns, got.pdelay_ns);
					compare_field("sync_ns", want.sync_ns, got.sync_ns);
					compare_field("announce_ns", want.announce_ns, got.announce_ns);
					compare_field("rate_ratio_on", want.rate_on, got.rate_on);
					compare_field("prop_delay_on", want.prop_on, got.prop_on);
				end
			end
			// start a stall burst at random while sink_idle is set
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (sink_idle && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 10);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycles);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Disable paths, a message latched while disabled, and re-enabling
	task automatic test_disable_and_enable();
		send_word(OP_EVAL, eval_word(1'b1, 1'b1, 1'b1));
		send_word(OP_LATCH, latch_word(8'sd10, 8'sd20, 8'sd30, 1'b1, 1'b0));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
		send_word(OP_EVAL, eval_word(1'b0, 1'b0, 1'b1));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b0));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
	endtask

	// Keep, restore, saturation and underflow edges, and an overwritten message
	task automatic test_interval_messages();
		send_word(OP_LATCH, latch_word(LOG_KEEP, LOG_KEEP, LOG_KEEP, 1'b0, 1'b1));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
		send_word(OP_LATCH, latch_word(8'sd127, -8'sd127, 8'sd34, 1'b1, 1'b0));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
		send_word(OP_LATCH, latch_word(8'sd35, -8'sd30, -8'sd29, 1'b0, 1'b0));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
		send_word(OP_LATCH, latch_word(LOG_INITIAL, LOG_INITIAL, LOG_INITIAL, 1'b1, 1'b1));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
		send_word(OP_LATCH, latch_word(-8'sd64, -8'sd63, 8'sd0, 1'b0, 1'b1));
		send_word(OP_LATCH, latch_word(8'sd1, -8'sd1, 8'sd125, 1'b1, 1'b0));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
	endtask

	// Extreme initial logs, loaded on enable and restored by a message
	task automatic test_register_writes();
		settle_port();
		set_init_logs(8'sd127, -8'sd128, 8'sd35);
		send_word(OP_EVAL, eval_word(1'b1, 1'b0, 1'b0));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
		send_word(OP_LATCH, latch_word(LOG_INITIAL, LOG_INITIAL, LOG_INITIAL, 1'b0, 1'b0));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
		settle_port();
		set_init_logs(-8'sd128, 8'sd127, -8'sd30);
		send_word(OP_EVAL, eval_word(1'b1, 1'b1, 1'b1));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
		send_word(OP_LATCH, latch_word(LOG_INITIAL, LOG_INITIAL, LOG_INITIAL, 1'b1, 1'b1));
		send_word(OP_EVAL, eval_word(1'b0, 1'b1, 1'b1));
	endtask

	// Random traffic in phases, each under its own set of initial logs
	task automatic test_random_traffic();
		for (int phase = 0; phase < 5; phase++) begin
			settle_port();
			case (phase)
				0:       set_init_logs(8'sd0, -8'sd3, 8'sd0);
				1:       set_init_logs(8'sd127, -8'sd128, 8'sd127);
				2:       set_init_logs(-8'sd128, 8'sd127, -8'sd128);
				3:       set_init_logs(8'sd34, 8'sd35, -8'sd30);
				default: set_init_logs(pick_log(), pick_log(), pick_log());
			endcase
			for (int i = 0; i < 300; i++) begin
				if (i % 50 == 0) begin
					src_idle  = ($urandom_range(0, 3) != 0);
					sink_idle = ($urandom_range(0, 3) != 0);
				end
				send_random_word();
			end
		end
	endtask

	// Full-rate tail: no gaps, no stalls
	task automatic test_quiet_tail();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		for (int i = 0; i < 50; i++)
			send_random_word();
	endtask

	initial begin : stimulus
		port_state  = FSM_NOT_ENABLED;
		msg_pending = 1'b0;
		held_msg    = '0;
		cur_log     = '{default: '0};
		cur_ns      = '{default: '0};
		compute_on  = 2'b00;
		init_log    = '{RST_INIT_PDELAY, RST_INIT_SYNC, RST_INIT_ANNOUNCE};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disable_and_enable();
		test_interval_messages();
		test_register_writes();
		test_random_traffic();
		test_quiet_tail();
		settle_port();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
rtl/core/ldsi_pkg.sv
rtl/core/ldsi_interval.sv
rtl/core/link_delay_sync_interval_setting.sv
rtl/core/ldsi_checker.sv
verif/link_delay_sync_interval_setting_test.sv
